### src/dlts_pkg.sv
`timescale 1ns / 1ps
package dlts_pkg;

  localparam int MAX_JOBS    = 16;
  localparam int JOB_IDX_W   = $clog2(MAX_JOBS);
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int TREE_LEVELS = JOB_IDX_W;
  localparam int STEP_W      = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

  localparam int TIME_W  = 16;
  localparam int TKEY_W  = TIME_W + 1;
  localparam int VEH_W   = 8;
  localparam int TYPE_W  = 4;
  localparam int CORE_W  = 5;
  localparam int CMP_W   = (CORE_W > CNT_W) ? CORE_W : CNT_W;

  // {not_eligible, primary, violation, period, vehicle, type, index}
  localparam int KEY_W = 1 + TKEY_W + TKEY_W + TIME_W + VEH_W + TYPE_W + JOB_IDX_W;
  localparam logic [TKEY_W-1:0] TKEY_MAX = {1'b1, {TIME_W{1'b0}}};

  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CORE_COUNT = 1'b0,
    REG_TRIAGE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CORE_W-1:0] core_count;
    logic              triage_enable;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] no_return_ms;
    logic [TIME_W-1:0] violation_ms;
    logic [TIME_W-1:0] job_period;
    logic [VEH_W-1:0]  vehicle_id;
    logic [TYPE_W-1:0] job_type;
    logic              vehicle_known;
  } entry_t;

  typedef struct packed {
    logic store;
    logic clear_count;
    logic clear_mask;
    logic search_first;
    logic search_step;
    logic mark_pick;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] picks;
  } dp_stat_t;

endpackage

### src/dlts_if.sv
`timescale 1ns / 1ps
interface dlts_job_if import dlts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] no_return_ms;
  logic [TIME_W-1:0] violation_ms;
  logic [TIME_W-1:0] job_period;
  logic [VEH_W-1:0]  vehicle_id;
  logic [TYPE_W-1:0] job_type;
  logic              vehicle_known;
  logic              last_job;

  modport source (output valid, no_return_ms, violation_ms, job_period, vehicle_id,
                  job_type, vehicle_known, last_job, input ready);
  modport sink   (input valid, no_return_ms, violation_ms, job_period, vehicle_id,
                  job_type, vehicle_known, last_job, output ready);
endinterface

interface dlts_pick_if import dlts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [JOB_IDX_W-1:0] job_index;
  logic                 last_pick;

  modport source (output valid, job_index, last_pick, input ready);
  modport sink   (input valid, job_index, last_pick, output ready);
endinterface

### src/deadline_top_k_job_selector.sv
`timescale 1ns / 1ps
// Deadline top-k job selector. Jobs load one per cycle into a 16-entry store;
// the job flagged last_job starts selection, which returns the load indices of
// the min(core_count, loaded) most urgent jobs, most urgent first, with
// last_pick on the final one. A job arriving with the store full is dropped.
// Each pick passes through the registered minimum tree, one tree level per
// cycle (log2 of the store depth levels in all), and is then presented until
// the sink takes it; no job is taken while a selection runs, and loading
// resumes the cycle after the last pick is taken.
// A core_count of zero returns nothing and simply empties the store.
module deadline_top_k_job_selector import dlts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  dlts_job_if.sink              job,
  dlts_pick_if.source           pick,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  entry_t   in_entry;

  assign in_entry.no_return_ms  = job.no_return_ms;
  assign in_entry.violation_ms  = job.violation_ms;
  assign in_entry.job_period    = job.job_period;
  assign in_entry.vehicle_id    = job.vehicle_id;
  assign in_entry.job_type      = job.job_type;
  assign in_entry.vehicle_known = job.vehicle_known;

  dlts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (job.valid),
    .in_last   (job.last_job),
    .in_ready  (job.ready),
    .out_valid (pick.valid),
    .out_ready (pick.ready),
    .out_last  (pick.last_pick),
    .stat      (stat),
    .cmd       (cmd)
  );

  dlts_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_entry   (in_entry),
    .cmd        (cmd),
    .stat       (stat),
    .pick_index (pick.job_index)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pick.valid && job.ready))
    else $error("pick offered while jobs are being loaded");

  a_resume_load: assert property (@(posedge clk) disable iff (rst)
    (pick.valid && pick.ready && pick.last_pick) |=> job.ready)
    else $error("loading did not resume after final pick");

  a_zero_cores: assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready && job.last_job && (cfg.core_count == '0)) |=>
    (job.ready && !pick.valid))
    else $error("selection started with zero cores");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready && job.last_job) |=> (stat.picks == '0) || !pick.valid)
    else $error("pick offered before search completed");

endmodule

### src/dlts_regs.sv
`timescale 1ns / 1ps
module dlts_regs import dlts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.core_count    <= CORE_W'(4);
      cfg.triage_enable <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_CORE_COUNT: cfg.core_count    <= pwdata[CORE_W-1:0];
        REG_TRIAGE:     cfg.triage_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CORE_COUNT: prdata = {{(APB_DATA_W-CORE_W){1'b0}}, cfg.core_count};
      REG_TRIAGE:     prdata = {{(APB_DATA_W-1){1'b0}}, cfg.triage_enable};
      default:        prdata = '0;
    endcase
  end

endmodule

### src/dlts_ctrl.sv
`timescale 1ns / 1ps
module dlts_ctrl import dlts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  left;
  logic              in_fire;
  logic              out_fire;
  logic              final_pick;

  assign in_ready   = (state == S_LOAD);
  assign out_valid  = (state == S_EMIT);
  assign in_fire    = in_ready && in_valid;
  assign out_fire   = out_valid && out_ready;
  assign final_pick = (left == CNT_W'(1));
  assign out_last   = final_pick;

  always_comb begin
    cmd              = '0;
    cmd.store        = in_fire;
    cmd.clear_mask   = in_fire && in_last;
    cmd.clear_count  = (in_fire && in_last && (stat.picks == '0)) ||
                       (out_fire && final_pick);
    cmd.search_first = (state == S_SEARCH) && (step == '0);
    cmd.search_step  = (state == S_SEARCH) && (step != '0);
    cmd.mark_pick    = out_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      step  <= '0;
      left  <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid && in_last && (stat.picks != '0)) begin
            state <= S_SEARCH;
            step  <= '0;
            left  <= stat.picks;
          end
        end
        S_SEARCH: begin
          // one tree level per cycle
          if (step == STEP_W'(TREE_LEVELS - 1)) begin
            state <= S_EMIT;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            left <= left - CNT_W'(1);
            step <= '0;
            if (final_pick) begin
              state <= S_LOAD;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

### src/dlts_datapath.sv
`timescale 1ns / 1ps
module dlts_datapath import dlts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  entry_t               in_entry,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [JOB_IDX_W-1:0] pick_index
);

  localparam int HALF = MAX_JOBS / 2;

  entry_t            store [MAX_JOBS];
  logic [CNT_W-1:0]  count;
  logic [MAX_JOBS-1:0] mask;
  logic [KEY_W-1:0]  leaf [MAX_JOBS];
  logic [KEY_W-1:0]  work [HALF];
  logic              full;
  logic [CNT_W-1:0]  count_after;

  function automatic logic [KEY_W-1:0] key_of(entry_t e, logic inelig,
                                              logic [JOB_IDX_W-1:0] idx, logic triage);
    logic [TKEY_W-1:0] pk;
    logic [TKEY_W-1:0] vk;
    if (!e.vehicle_known || (triage && (e.no_return_ms == '0))) begin
      pk = TKEY_MAX;
    end else begin
      pk = {1'b0, e.no_return_ms};
    end
    vk = e.vehicle_known ? {1'b0, e.violation_ms} : TKEY_MAX;
    return {inelig, pk, vk, e.job_period, e.vehicle_id, e.job_type, idx};
  endfunction

  // settle eligibility first so entries that were never loaded stay out of the compare
  function automatic logic [KEY_W-1:0] kmin(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    if (a[KEY_W-1] != b[KEY_W-1]) return a[KEY_W-1] ? b : a;
    return (a < b) ? a : b;
  endfunction

  assign full        = (count == CNT_W'(MAX_JOBS));
  assign count_after = full ? count : count + CNT_W'(1);
  assign stat.picks  = (CMP_W'(cfg.core_count) < CMP_W'(count_after)) ?
                       CNT_W'(cfg.core_count) : count_after;
  assign pick_index  = work[0][JOB_IDX_W-1:0];

  // entries already picked or beyond the load count sort last
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      leaf[i] = key_of(store[i], !(CNT_W'(i) < count) || mask[i],
                       JOB_IDX_W'(i), cfg.triage_enable);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      store[count[JOB_IDX_W-1:0]] <= in_entry;
    end
    if (cmd.search_first) begin
      for (int i = 0; i < HALF; i++) begin
        work[i] <= kmin(leaf[2*i], leaf[2*i+1]);
      end
    end else if (cmd.search_step) begin
      for (int i = 0; i < HALF / 2; i++) begin
        work[i] <= kmin(work[2*i], work[2*i+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mask  <= '0;
    end else begin
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.store && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.clear_mask) begin
        mask <= '0;
      end else if (cmd.mark_pick) begin
        mask[pick_index] <= 1'b1;
      end
    end
  end

endmodule
